@@ rtl/rcof_pkg.sv @@
`timescale 1ns / 1ps
package rcof_pkg;

  // Fixed-point format of ray positions, steps and trig values
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 27;
  localparam int STEP_W    = 18;
  localparam int TRIG_W    = 18;
  localparam int ANG_W     = 11;
  localparam int ROM_DEPTH = 540;
  localparam int ROM_AW    = 10;
  localparam int ROOT_BITS = 8;
  localparam int DIV_BITS  = 25;
  localparam int CELL_W    = 11;

  localparam logic [6:0] RANGE_RESET = 7'd40;
  localparam logic [7:0] FOV_RESET   = 8'd45;

  // Register indexes and item functions
  localparam logic CFG_RANGE  = 1'b0;
  localparam logic CFG_FOV    = 1'b1;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SCAN  = 1'b1;

  localparam int RED_STEP = 25;
  localparam int NUM_OBJ  = 10;

  // Angles in Q.30
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIG,
    S_END,
    S_SQ,
    S_SQRT,
    S_DXI,
    S_DX,
    S_DYI,
    S_DY,
    S_RAY,
    S_SAMP,
    S_CHECK,
    S_CLOSE
  } state_t;

  typedef struct packed {
    logic map_wr;
    logic start;
    logic trig_rd;
    logic end_calc;
    logic sq_calc;
    logic sqrt_step;
    logic div_load;
    logic div_sel;
    logic div_step;
    logic keep_sx;
    logic keep_sy;
    logic ray_init;
    logic samp_rd;
    logic advance;
    logic next_ray;
    logic emit_obj;
    logic emit_close;
  } cmd_t;

  typedef struct packed {
    logic fov_zero;
    logic it_last;
    logic rays_last;
    logic steps_last;
    logic outside;
    logic obj_new;
    logic black;
    logic out_free;
  } sts_t;

  typedef logic [2*TRIG_W-1:0] trig_rom_t [ROM_DEPTH];

  // Two more powers of x on a Q.30 term
  function automatic logic [63:0] term_sq(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] u;
    u = (t * x) >> 30;
    u = (u * x) >> 30;
    return u;
  endfunction

  // sin or cos of a whole degree, Taylor series in Q.30, rounded to Q.16
  function automatic logic signed [TRIG_W-1:0] fix_trig(input int mag, input logic want_cos);
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] ngs;
    logic signed [63:0] res;
    logic signed [63:0] r;
    logic neg;
    neg = 1'b0;
    a = ((64'(mag) * 64'd31416) << 30);
    a = (a + 64'd900000) / 64'd1800000;
    if (want_cos) a = a + HALF_PI_Q30;
    if (a >= TWO_PI_Q30) a = a - TWO_PI_Q30;
    if (a >= TWO_PI_Q30) a = a - TWO_PI_Q30;
    if (a >= PI_Q30) begin
      a = a - PI_Q30;
      neg = !neg;
    end
    if (a > HALF_PI_Q30) a = PI_Q30 - a;
    x = a;
    t = x;
    pos = x;
    ngs = 64'd0;
    t = term_sq(t, x) / 64'd6;   ngs = ngs + t;
    t = term_sq(t, x) / 64'd20;  pos = pos + t;
    t = term_sq(t, x) / 64'd42;  ngs = ngs + t;
    t = term_sq(t, x) / 64'd72;  pos = pos + t;
    t = term_sq(t, x) / 64'd110; ngs = ngs + t;
    t = term_sq(t, x) / 64'd156; pos = pos + t;
    t = term_sq(t, x) / 64'd210; ngs = ngs + t;
    t = term_sq(t, x) / 64'd272; pos = pos + t;
    t = term_sq(t, x) / 64'd342; ngs = ngs + t;
    t = term_sq(t, x) / 64'd420; pos = pos + t;
    t = term_sq(t, x) / 64'd506; ngs = ngs + t;
    t = term_sq(t, x) / 64'd600; pos = pos + t;
    res = $signed(pos) - $signed(ngs);
    if (res < 0) res = 64'sd0;
    r = (res + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (neg) r = -r;
    return TRIG_W'(r);
  endfunction

  // Entry i holds {cos(i deg), sin(i deg)}
  function automatic trig_rom_t trig_rom_build();
    trig_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = {fix_trig(i, 1'b1), fix_trig(i, 1'b0)};
    end
    return rom;
  endfunction

  // Object number of a red level, 0 when the level names no object
  function automatic logic [3:0] red_id(input logic [7:0] r);
    logic [3:0] id;
    id = 4'd0;
    for (int i = 1; i <= NUM_OBJ; i++) begin
      if (r == 8'(RED_STEP * i)) id = 4'(i);
    end
    return id;
  endfunction

endpackage

@@ rtl/fan_ray_cast_object_finder_unit.sv @@
`timescale 1ns / 1ps
// Fan ray-cast object finder.
// Input channel (in_valid / in_stall): func 0 writes one map cell from
// x_pos, y_pos and the colour and gives no result.
// func 1 casts 2*half_fov rays around heading from the origin cell and
// gives one word per newly seen object, then a closing word with last set.
// Output channel (out_valid / out_stall) has a single output register;
// while it is stalled the scan waits at the next word it must deliver.
// Config: cfg_we writes cfg_data to range_cells (index 0) or half_fov
// (index 1); the user must write only while no scan is running, which
// the block itself does not enforce.
// Timing: each ray is set up by a trig lookup, a square root and two
// divides on one shared divider, then each sample is a map read and
// then a check, through the single map read port. in_stall stays high
// for the whole scan.
// Reset: range_cells 40, half_fov 45, seen flags and scan count zero;
// the map is undefined until written.
module fan_ray_cast_object_finder_unit #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [6:0]  in_x_pos,
  input  logic [6:0]  in_y_pos,
  input  logic [8:0]  in_heading,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_object_id,
  output logic [15:0] out_scan_index,
  output logic        out_last
);

  rcof_pkg::cmd_t cmd;
  rcof_pkg::sts_t sts;

  rcof_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcof_dp #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_heading     (in_heading),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_object_id  (out_object_id),
    .out_scan_index (out_scan_index),
    .out_last       (out_last)
  );

endmodule

@@ rtl/rcof_ctrl.sv @@
`timescale 1ns / 1ps
module rcof_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_stall,
  input  rcof_pkg::sts_t sts,
  output rcof_pkg::cmd_t cmd
);

  rcof_pkg::state_t state_r;
  rcof_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcof_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != rcof_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      rcof_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_func == rcof_pkg::FUNC_WRITE) begin
            cmd.map_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.fov_zero ? rcof_pkg::S_CLOSE : rcof_pkg::S_TRIG;
          end
        end
      end
      rcof_pkg::S_TRIG: begin
        cmd.trig_rd = 1'b1;
        state_nxt = rcof_pkg::S_END;
      end
      rcof_pkg::S_END: begin
        cmd.end_calc = 1'b1;
        state_nxt = rcof_pkg::S_SQ;
      end
      rcof_pkg::S_SQ: begin
        cmd.sq_calc = 1'b1;
        state_nxt = rcof_pkg::S_SQRT;
      end
      rcof_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.it_last) state_nxt = rcof_pkg::S_DXI;
      end
      rcof_pkg::S_DXI: begin
        cmd.div_load = 1'b1;
        cmd.div_sel = 1'b0;
        state_nxt = rcof_pkg::S_DX;
      end
      rcof_pkg::S_DX: begin
        cmd.div_step = 1'b1;
        if (sts.it_last) state_nxt = rcof_pkg::S_DYI;
      end
      rcof_pkg::S_DYI: begin
        cmd.keep_sx = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_sel = 1'b1;
        state_nxt = rcof_pkg::S_DY;
      end
      rcof_pkg::S_DY: begin
        cmd.div_step = 1'b1;
        if (sts.it_last) state_nxt = rcof_pkg::S_RAY;
      end
      rcof_pkg::S_RAY: begin
        cmd.keep_sy = 1'b1;
        cmd.ray_init = 1'b1;
        state_nxt = rcof_pkg::S_SAMP;
      end
      rcof_pkg::S_SAMP: begin
        if (sts.outside) begin
          cmd.next_ray = 1'b1;
          state_nxt = sts.rays_last ? rcof_pkg::S_CLOSE : rcof_pkg::S_TRIG;
        end else begin
          cmd.samp_rd = 1'b1;
          state_nxt = rcof_pkg::S_CHECK;
        end
      end
      rcof_pkg::S_CHECK: begin
        if (sts.obj_new && !sts.out_free) begin
          state_nxt = rcof_pkg::S_CHECK;
        end else if (sts.black && !sts.obj_new) begin
          cmd.next_ray = 1'b1;
          state_nxt = sts.rays_last ? rcof_pkg::S_CLOSE : rcof_pkg::S_TRIG;
        end else begin
          cmd.emit_obj = sts.obj_new;
          if (sts.steps_last) begin
            cmd.next_ray = 1'b1;
            state_nxt = sts.rays_last ? rcof_pkg::S_CLOSE : rcof_pkg::S_TRIG;
          end else begin
            cmd.advance = 1'b1;
            state_nxt = rcof_pkg::S_SAMP;
          end
        end
      end
      rcof_pkg::S_CLOSE: begin
        if (sts.out_free) begin
          cmd.emit_close = 1'b1;
          state_nxt = rcof_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rcof_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rcof_dp.sv @@
`timescale 1ns / 1ps
module rcof_dp #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_idx,
  input  logic [7:0]     cfg_data,
  input  logic [6:0]     in_x_pos,
  input  logic [6:0]     in_y_pos,
  input  logic [8:0]     in_heading,
  input  logic [7:0]     in_blue,
  input  logic [7:0]     in_green,
  input  logic [7:0]     in_red,
  input  rcof_pkg::cmd_t cmd,
  output rcof_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     out_object_id,
  output logic [15:0]    out_scan_index,
  output logic           out_last
);

  localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW        = $clog2(MAP_CELLS);
  localparam int FB        = rcof_pkg::FRAC_BITS;
  localparam int PW        = rcof_pkg::POS_W;
  localparam int SW        = rcof_pkg::STEP_W;
  localparam int TW        = rcof_pkg::TRIG_W;
  localparam int CW        = rcof_pkg::CELL_W;
  localparam int DB        = rcof_pkg::DIV_BITS;
  localparam rcof_pkg::trig_rom_t TRIG_ROM = rcof_pkg::trig_rom_build();

  logic [6:0]  range_r;
  logic [7:0]  fov_r;
  logic [6:0]  x0_r;
  logic [6:0]  y0_r;
  logic signed [rcof_pkg::ANG_W-1:0] s_r;
  logic [8:0]  rays_r;
  logic [2*TW-1:0] rom_r;
  logic        neg_r;
  logic signed [8:0] dx_r;
  logic signed [8:0] dy_r;
  logic [15:0] d2_r;
  logic [rcof_pkg::ROOT_BITS-1:0] root_r;
  logic [4:0]  it_r;
  logic [DB-1:0] nq_r;
  logic [9:0]  rem_r;
  logic [7:0]  steps_r;
  logic signed [SW-1:0] sx_r;
  logic signed [SW-1:0] sy_r;
  logic signed [PW-1:0] posx_r;
  logic signed [PW-1:0] posy_r;
  logic [7:0]  left_r;
  logic [23:0] col_r;
  logic [rcof_pkg::NUM_OBJ-1:0] seen_r;
  logic [15:0] scan_r;
  logic        out_valid_r;
  logic [3:0]  out_id_r;
  logic [15:0] out_idx_r;
  logic        out_last_r;
  logic [23:0] map_mem [MAP_CELLS];

  // Position to cell: truncate toward zero when negative, round half up when positive
  function automatic logic [CW:0] pick(input logic signed [PW-1:0] p, input logic [CW-1:0] size);
    logic [PW-1:0] m;
    logic [CW-1:0] c;
    logic ok;
    if (p < 0) begin
      m = PW'(-p);
      c = '0;
      ok = (m[PW-1:FB] == '0);
    end else begin
      c = CW'(p[PW-1:FB]);
      if (p[FB-1] && (c < size - CW'(1))) c = c + CW'(1);
      ok = (c < size);
    end
    return {ok, c};
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= rcof_pkg::RANGE_RESET;
      fov_r   <= rcof_pkg::FOV_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        rcof_pkg::CFG_RANGE: range_r <= cfg_data[6:0];
        rcof_pkg::CFG_FOV:   fov_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // trig lookup address
  logic signed [rcof_pkg::ANG_W-1:0] s_abs;
  assign s_abs = s_r[rcof_pkg::ANG_W-1] ? -s_r : s_r;

  // ray end point
  logic signed [TW-1:0] cos_v;
  logic signed [TW-1:0] sin_v;
  logic signed [7:0]    r_s;
  logic signed [25:0]   prod_c;
  logic signed [25:0]   prod_s;
  logic signed [25:0]   ex;
  logic signed [25:0]   ey;
  logic [25:0]          ex_m;
  logic [25:0]          ey_m;
  logic signed [10:0]   tx;
  logic signed [10:0]   ty;
  logic signed [10:0]   dx_v;
  logic signed [10:0]   dy_v;
  assign cos_v  = $signed(rom_r[2*TW-1:TW]);
  assign sin_v  = neg_r ? -$signed(rom_r[TW-1:0]) : $signed(rom_r[TW-1:0]);
  assign r_s    = $signed({1'b0, range_r});
  assign prod_c = r_s * cos_v;
  assign prod_s = r_s * sin_v;
  assign ex     = $signed({3'b0, x0_r, 16'b0}) + prod_c;
  assign ey     = $signed({3'b0, y0_r, 16'b0}) - prod_s;
  assign ex_m   = ex[25] ? 26'(-ex) : 26'(ex);
  assign ey_m   = ey[25] ? 26'(-ey) : 26'(ey);
  assign tx     = ex[25] ? -$signed({1'b0, ex_m[25:FB]}) : $signed({1'b0, ex_m[25:FB]});
  assign ty     = ey[25] ? -$signed({1'b0, ey_m[25:FB]}) : $signed({1'b0, ey_m[25:FB]});
  assign dx_v   = tx - $signed({4'b0, x0_r});
  assign dy_v   = ty - $signed({4'b0, y0_r});

  // squared length
  logic signed [17:0] sq_x;
  logic signed [17:0] sq_y;
  logic [17:0]        sq_sum;
  assign sq_x   = dx_r * dx_r;
  assign sq_y   = dy_r * dy_r;
  assign sq_sum = $unsigned(sq_x) + $unsigned(sq_y);

  // square root, one result bit per cycle
  logic [rcof_pkg::ROOT_BITS-1:0] trial;
  logic [15:0]                    trial_sq;
  assign trial    = root_r | (rcof_pkg::ROOT_BITS'(1) << it_r[2:0]);
  assign trial_sq = trial * trial;

  // rounded divide, one quotient bit per cycle
  logic signed [8:0] d_sel;
  logic [7:0]        d_mag;
  logic [7:0]        steps_v;
  logic [10:0]       r2;
  logic [10:0]       dv;
  logic              ge;
  logic [16:0]       q;
  assign d_sel   = cmd.div_sel ? dy_r : dx_r;
  assign d_mag   = d_sel[8] ? 8'(-d_sel) : d_sel[7:0];
  assign steps_v = root_r + 8'd1;
  assign r2      = {rem_r, nq_r[DB-1]};
  assign dv      = {2'b0, steps_r, 1'b0};
  assign ge      = (r2 >= dv);
  assign q       = nq_r[16:0];

  // sample cell and map addresses
  logic [CW:0]   px;
  logic [CW:0]   py;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          w_in;
  assign px    = pick(posx_r, CW'(MAP_WIDTH));
  assign py    = pick(posy_r, CW'(MAP_HEIGHT));
  assign raddr = AW'(py[CW-1:0]) * AW'(MAP_WIDTH) + AW'(px[CW-1:0]);
  assign waddr = AW'(in_y_pos) * AW'(MAP_WIDTH) + AW'(in_x_pos);
  assign w_in  = ({4'b0, in_x_pos} < CW'(MAP_WIDTH)) && ({4'b0, in_y_pos} < CW'(MAP_HEIGHT));

  // sample colour check
  logic [3:0] obj_id;
  logic       is_obj;
  assign obj_id = rcof_pkg::red_id(col_r[23:16]);
  assign is_obj = (col_r[15:0] == 16'd0) && (obj_id != 4'd0);

  // map memory
  always_ff @(posedge clk) begin
    if (cmd.map_wr && w_in) map_mem[waddr] <= {in_red, in_green, in_blue};
    if (cmd.samp_rd) col_r <= map_mem[raddr];
  end

  // trig table
  always_ff @(posedge clk) begin
    if (cmd.trig_rd) begin
      rom_r <= TRIG_ROM[s_abs[rcof_pkg::ROM_AW-1:0]];
      neg_r <= s_r[rcof_pkg::ANG_W-1];
    end
  end

  // ray setup and stepping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x0_r   <= in_x_pos;
      y0_r   <= in_y_pos;
      s_r    <= $signed({2'b0, in_heading}) - $signed({3'b0, fov_r});
      rays_r <= {fov_r, 1'b0};
    end
    if (cmd.next_ray) begin
      s_r    <= s_r + 11'sd1;
      rays_r <= rays_r - 9'd1;
    end
    if (cmd.end_calc) begin
      dx_r <= dx_v[8:0];
      dy_r <= dy_v[8:0];
    end
    if (cmd.sq_calc) begin
      d2_r   <= sq_sum[15:0];
      root_r <= '0;
      it_r   <= 5'(rcof_pkg::ROOT_BITS - 1);
    end
    if (cmd.sqrt_step) begin
      if (trial_sq <= d2_r) root_r <= trial;
      it_r <= it_r - 5'd1;
    end
    if (cmd.div_load) begin
      nq_r    <= {d_mag, 17'b0} + DB'(steps_v);
      rem_r   <= '0;
      it_r    <= 5'(DB - 1);
      steps_r <= steps_v;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 10'(r2 - dv) : r2[9:0];
      nq_r  <= {nq_r[DB-2:0], ge};
      it_r  <= it_r - 5'd1;
    end
    if (cmd.keep_sx) sx_r <= dx_r[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (cmd.keep_sy) sy_r <= dy_r[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (cmd.ray_init) begin
      posx_r <= $signed({4'b0, x0_r, 16'b0});
      posy_r <= $signed({4'b0, y0_r, 16'b0});
      left_r <= steps_r;
    end
    if (cmd.advance) begin
      posx_r <= posx_r + PW'(sx_r);
      posy_r <= posy_r + PW'(sy_r);
      left_r <= left_r - 8'd1;
    end
  end

  // seen flags, scan count and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.emit_obj) begin
        seen_r[obj_id - 4'd1] <= 1'b1;
        out_valid_r <= 1'b1;
      end
      if (cmd.emit_close) begin
        scan_r      <= scan_r + 16'd1;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_obj) begin
      out_id_r   <= obj_id;
      out_last_r <= 1'b0;
    end
    if (cmd.emit_close) begin
      out_id_r   <= 4'd0;
      out_last_r <= 1'b1;
    end
    if (cmd.emit_obj || cmd.emit_close) out_idx_r <= scan_r;
  end

  assign out_valid      = out_valid_r;
  assign out_object_id  = out_id_r;
  assign out_scan_index = out_idx_r;
  assign out_last       = out_last_r;

  // status to the controller
  assign sts.fov_zero   = (fov_r == 8'd0);
  assign sts.it_last    = (it_r == 5'd0);
  assign sts.rays_last  = (rays_r == 9'd1);
  assign sts.steps_last = (left_r == 8'd1);
  assign sts.outside    = !(px[CW] && py[CW]);
  assign sts.obj_new    = is_obj && !seen_r[obj_id - 4'd1];
  assign sts.black      = (col_r == 24'd0);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule
